// ----- design/rvx_pkg.sv -----
// ----------------------------------------------------------------------------
// rvx_pkg : shared types and codes for the RV32IM execute unit
// Operation codes, item structs and the front-to-back classification record.
// ----------------------------------------------------------------------------
package rvx_pkg;

	localparam int QueueDepth = 4;
	localparam int DivCycles = 32;

	localparam logic [5:0] OP_LUI = 6'd0, OP_AUIPC = 6'd1, OP_JAL = 6'd2, OP_JALR = 6'd3;
	localparam logic [5:0] OP_BEQ = 6'd4, OP_BNE = 6'd5, OP_BLT = 6'd6, OP_BGE = 6'd7;
	localparam logic [5:0] OP_BLTU = 6'd8, OP_BGEU = 6'd9;
	localparam logic [5:0] OP_LB = 6'd10, OP_LH = 6'd11, OP_LW = 6'd12, OP_LBU = 6'd13;
	localparam logic [5:0] OP_LHU = 6'd14, OP_SB = 6'd15, OP_SH = 6'd16, OP_SW = 6'd17;
	localparam logic [5:0] OP_ADDI = 6'd18, OP_SLTI = 6'd19, OP_SLTIU = 6'd20;
	localparam logic [5:0] OP_XORI = 6'd21, OP_ORI = 6'd22, OP_ANDI = 6'd23;
	localparam logic [5:0] OP_SLLI = 6'd24, OP_SRLI = 6'd25, OP_SRAI = 6'd26;
	localparam logic [5:0] OP_ADD = 6'd27, OP_SUB = 6'd28, OP_SLL = 6'd29, OP_SLT = 6'd30;
	localparam logic [5:0] OP_SLTU = 6'd31, OP_XOR = 6'd32, OP_SRL = 6'd33, OP_SRA = 6'd34;
	localparam logic [5:0] OP_OR = 6'd35, OP_AND = 6'd36, OP_MUL = 6'd37, OP_MULH = 6'd38;
	localparam logic [5:0] OP_MULHSU = 6'd39, OP_MULHU = 6'd40, OP_DIV = 6'd41;
	localparam logic [5:0] OP_DIVU = 6'd42, OP_REM = 6'd43, OP_REMU = 6'd44;
	localparam logic [5:0] OP_NOP = 6'd45, OP_ECALL = 6'd46;

	typedef struct packed {
		logic [5:0]  mode;
		logic [31:0] src_a;
		logic [31:0] src_b;
		logic [31:0] imm_raw;
		logic [31:0] pc;
		logic [31:0] load_word;
	} in_item_t;

	typedef struct packed {
		logic        rd_write;
		logic [31:0] rd_value;
		logic [31:0] next_pc;
		logic [31:0] mem_addr;
		logic [31:0] store_data;
		logic [3:0]  byte_enable;
		logic        syscall;
	} out_item_t;

	// classified item: everything but the multiply/divide value is final here
	typedef struct packed {
		out_item_t   res;
		logic        is_mul;
		logic        is_div;
		logic [1:0]  sub;
		logic [31:0] a;
		logic [31:0] b;
	} work_t;

endpackage

// ----- design/rvx_front.sv -----
// ----------------------------------------------------------------------------
// rvx_front : accept and classify
// Computes all simple results in one registered stage and tags mul/div items.
// ----------------------------------------------------------------------------
module rvx_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  rvx_pkg::in_item_t in_data,
	output logic              w_valid,
	input  logic              w_ready,
	output rvx_pkg::work_t    w_data
);
	rvx_pkg::work_t w_c;
	logic [31:0] a, b, imm, imm_i, imm_b, imm_j, addr, pc4, lw, opb;
	logic [4:0] sh;
	logic [5:0] m;
	logic take;
	logic [63:0] sra_x;
	logic [15:0] half;
	logic [7:0] byte_v;
	logic valid_s1;

	always_comb begin
		m = in_data.mode;
		a = in_data.src_a;
		b = in_data.src_b;
		imm = in_data.imm_raw;
		lw = in_data.load_word;
		pc4 = in_data.pc + 32'd4;
		imm_i = {{20{imm[11]}}, imm[11:0]};
		imm_b = {{19{imm[12]}}, imm[12:0]};
		imm_j = {{11{imm[20]}}, imm[20:0]};
		addr = a + imm_i;
		opb = (m inside {[rvx_pkg::OP_ADDI:rvx_pkg::OP_SRAI]}) ? imm_i : b;
		sh = opb[4:0];
		sra_x = {{32{a[31]}}, a} >> sh;
		half = addr[1] ? lw[31:16] : lw[15:0];
		byte_v = lw[8*addr[1:0] +: 8];
		take = 1'b0;
		w_c = '0;
		w_c.res.next_pc = pc4;
		w_c.a = a;
		w_c.b = b;
		case (m)
			rvx_pkg::OP_BEQ:  take = (a == b);
			rvx_pkg::OP_BNE:  take = (a != b);
			rvx_pkg::OP_BLT:  take = ($signed(a) < $signed(b));
			rvx_pkg::OP_BGE:  take = !($signed(a) < $signed(b));
			rvx_pkg::OP_BLTU: take = (a < b);
			rvx_pkg::OP_BGEU: take = (a >= b);
			default:          take = 1'b0;
		endcase
		if (m inside {[rvx_pkg::OP_BEQ:rvx_pkg::OP_BGEU]} && take)
			w_c.res.next_pc = in_data.pc + imm_b;
		if (m inside {[rvx_pkg::OP_LB:rvx_pkg::OP_SW]})
			w_c.res.mem_addr = addr;
		if (m inside {[rvx_pkg::OP_LUI:rvx_pkg::OP_JALR], [rvx_pkg::OP_LB:rvx_pkg::OP_LHU],
				[rvx_pkg::OP_ADDI:rvx_pkg::OP_REMU]})
			w_c.res.rd_write = 1'b1;
		w_c.is_mul = m inside {[rvx_pkg::OP_MUL:rvx_pkg::OP_MULHU]};
		w_c.is_div = m inside {[rvx_pkg::OP_DIV:rvx_pkg::OP_REMU]};
		w_c.sub = w_c.is_mul ? 2'(m - rvx_pkg::OP_MUL) : 2'(m - rvx_pkg::OP_DIV);
		case (m)
			rvx_pkg::OP_LUI:   w_c.res.rd_value = imm;
			rvx_pkg::OP_AUIPC: w_c.res.rd_value = in_data.pc + imm;
			rvx_pkg::OP_JAL: begin
				w_c.res.rd_value = pc4;
				w_c.res.next_pc = in_data.pc + imm_j;
			end
			rvx_pkg::OP_JALR: begin
				w_c.res.rd_value = pc4;
				w_c.res.next_pc = addr & 32'hFFFF_FFFE;
			end
			rvx_pkg::OP_LB:  w_c.res.rd_value = {{24{byte_v[7]}}, byte_v};
			rvx_pkg::OP_LH:  w_c.res.rd_value = {{16{half[15]}}, half};
			rvx_pkg::OP_LW:  w_c.res.rd_value = lw;
			rvx_pkg::OP_LBU: w_c.res.rd_value = {24'd0, byte_v};
			rvx_pkg::OP_LHU: w_c.res.rd_value = {16'd0, half};
			rvx_pkg::OP_SB: begin
				w_c.res.store_data = {24'd0, b[7:0]} << (8 * addr[1:0]);
				w_c.res.byte_enable = 4'b0001 << addr[1:0];
			end
			rvx_pkg::OP_SH: begin
				w_c.res.store_data = addr[1] ? {b[15:0], 16'd0} : {16'd0, b[15:0]};
				w_c.res.byte_enable = addr[1] ? 4'b1100 : 4'b0011;
			end
			rvx_pkg::OP_SW: begin
				w_c.res.store_data = b;
				w_c.res.byte_enable = 4'hF;
			end
			rvx_pkg::OP_ADDI, rvx_pkg::OP_ADD: w_c.res.rd_value = a + opb;
			rvx_pkg::OP_SUB: w_c.res.rd_value = a - b;
			rvx_pkg::OP_SLTI, rvx_pkg::OP_SLT:
				w_c.res.rd_value = {31'd0, $signed(a) < $signed(opb)};
			rvx_pkg::OP_SLTIU, rvx_pkg::OP_SLTU: w_c.res.rd_value = {31'd0, a < opb};
			rvx_pkg::OP_XORI, rvx_pkg::OP_XOR: w_c.res.rd_value = a ^ opb;
			rvx_pkg::OP_ORI, rvx_pkg::OP_OR:   w_c.res.rd_value = a | opb;
			rvx_pkg::OP_ANDI, rvx_pkg::OP_AND: w_c.res.rd_value = a & opb;
			rvx_pkg::OP_SLLI, rvx_pkg::OP_SLL: w_c.res.rd_value = a << sh;
			rvx_pkg::OP_SRLI, rvx_pkg::OP_SRL: w_c.res.rd_value = a >> sh;
			rvx_pkg::OP_SRAI, rvx_pkg::OP_SRA: w_c.res.rd_value = sra_x[31:0];
			rvx_pkg::OP_ECALL: w_c.res.syscall = 1'b1;
			default: ;
		endcase
	end

	// one register stage; advance whenever the slot is empty or being taken
	assign in_ready = !valid_s1 || w_ready;
	assign w_valid = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			w_data <= w_c;
		end
	end
endmodule

// ----- design/rvx_queue.sv -----
// ----------------------------------------------------------------------------
// rvx_queue : short FIFO between front and back
// Register-based ring of classified items.
// ----------------------------------------------------------------------------
module rvx_queue #(
	parameter int Depth = rvx_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           i_valid,
	output logic           i_ready,
	input  rvx_pkg::work_t i_data,
	output logic           o_valid,
	input  logic           o_ready,
	output rvx_pkg::work_t o_data
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
	rvx_pkg::work_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign i_ready = (cnt_q != (AW+1)'(Depth));
	assign o_valid = (cnt_q != '0);
	assign o_data = mem_q[rp_q];
	assign push = i_valid && i_ready;
	assign pop = o_valid && o_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (pop) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= i_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (AW+1)'(Depth)) else $error("queue count beyond depth");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == (AW+1)'(Depth)) && !pop |=> cnt_q == (AW+1)'(Depth))
		else $error("full queue lost an item");
	a_empty_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) && !push |=> cnt_q == '0) else $error("empty queue gained an item");
endmodule

// ----- design/rvx_back.sv -----
// ----------------------------------------------------------------------------
// rvx_back : multiply and divide, result register
// Two-stage multiplier from 16- and 17-bit partial products; radix-2 divider, 1 bit a cycle.
// ----------------------------------------------------------------------------
module rvx_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               w_valid,
	output logic               w_ready,
	input  rvx_pkg::work_t     w_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rvx_pkg::out_item_t out_data
);
	localparam logic [1:0] ST_IDLE = 2'd0, ST_MUL1 = 2'd1, ST_MUL2 = 2'd2, ST_DIV = 2'd3;
	logic [1:0] state_q;
	rvx_pkg::work_t cur_q;
	logic ov_q;
	logic take;
	// multiply: signed 33-bit operands split into a 16-bit high and a 17-bit low part
	logic signed [32:0] ma, mb;
	logic signed [34:0] p_hh_q, p_hl_q, p_lh_q;
	logic [33:0] p_ll_q;
	logic [65:0] prod;
	// divide
	logic [31:0] dq_q, dr_q, dd_q;
	logic [5:0] dc_q;
	logic neg_q, div_zero_q, div_ovf_q;
	logic [32:0] trial;
	logic [31:0] rem_n, quo_n, quo, rmd, dres;
	rvx_pkg::out_item_t fin;

	assign take = w_valid && w_ready;
	assign w_ready = (state_q == ST_IDLE) && (!out_valid || out_ready);

	always_comb begin
		ma = {w_data.sub != 2'd3 && w_data.a[31], w_data.a};
		mb = {w_data.sub == 2'd1 && w_data.b[31], w_data.b};
		prod = 66'($signed({p_hh_q, 34'd0})) + 66'($signed({p_hl_q, 17'd0}))
			+ 66'($signed({p_lh_q, 17'd0})) + 66'(p_ll_q);
		trial = {dr_q, dq_q[31]} - {1'b0, dd_q};
		rem_n = trial[32] ? {dr_q[30:0], dq_q[31]} : trial[31:0];
		quo_n = {dq_q[30:0], !trial[32]};
		quo = neg_q ? -quo_n : quo_n;
		rmd = neg_q ? -rem_n : rem_n;
		if (div_zero_q) begin
			dres = cur_q.sub[1] ? cur_q.a : 32'hFFFF_FFFF;
		end else if (div_ovf_q) begin
			dres = cur_q.sub[1] ? 32'd0 : 32'h8000_0000;
		end else begin
			dres = cur_q.sub[1] ? rmd : quo;
		end
		fin = cur_q.res;
		if (state_q == ST_MUL2)
			fin.rd_value = (cur_q.sub == 2'd0) ? prod[31:0] : prod[63:32];
		else
			fin.rd_value = dres;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			if (out_valid && out_ready) ov_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						if (w_data.is_mul) state_q <= ST_MUL1;
						else if (w_data.is_div) state_q <= ST_DIV;
						else ov_q <= 1'b1;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: begin
					state_q <= ST_IDLE;
					ov_q <= 1'b1;
				end
				ST_DIV: begin
					if (dc_q == '0 || div_zero_q || div_ovf_q) begin
						state_q <= ST_IDLE;
						ov_q <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cur_q <= w_data;
			if (!w_data.is_mul && !w_data.is_div) out_data <= w_data.res;
			p_hh_q <= 35'($signed(ma[32:17]) * $signed(mb[32:17]));
			p_hl_q <= 35'($signed(ma[32:17]) * $signed({1'b0, mb[16:0]}));
			p_lh_q <= 35'($signed({1'b0, ma[16:0]}) * $signed(mb[32:17]));
			p_ll_q <= 34'(ma[16:0] * mb[16:0]);
			// signed division works on magnitudes
			if (!w_data.sub[0] && w_data.a[31]) dq_q <= -w_data.a;
			else dq_q <= w_data.a;
			if (!w_data.sub[0] && w_data.b[31]) dd_q <= -w_data.b;
			else dd_q <= w_data.b;
			neg_q <= !w_data.sub[0] && (w_data.sub[1] ? w_data.a[31]
				: (w_data.a[31] ^ w_data.b[31]));
			div_zero_q <= (w_data.b == '0);
			div_ovf_q <= !w_data.sub[0] && w_data.a == 32'h8000_0000 && w_data.b == '1;
			dr_q <= '0;
			dc_q <= 6'(rvx_pkg::DivCycles - 1);
		end
		if (state_q == ST_DIV) begin
			// shift-subtract one quotient bit
			dr_q <= rem_n;
			dq_q <= quo_n;
			dc_q <= dc_q - 1'b1;
		end
		if (state_q == ST_MUL2
				|| (state_q == ST_DIV && (dc_q == '0 || div_zero_q || div_ovf_q)))
			out_data <= fin;
	end

	assign out_valid = ov_q;

	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !w_ready) else $error("took an item while busy");
	a_mul_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL1 |=> state_q == ST_MUL2) else $error("multiply sequence broken");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
endmodule

// ----- design/rv32im_execute_unit_top.sv -----
// ----------------------------------------------------------------------------
// rv32im_execute_unit_top : RV32IM integer execute unit
// Front classifies and computes simple results, a queue decouples, the back
// runs multiply and divide and holds the result register.
// Throughput: one item a cycle for plain items while out_ready holds; multiply
// and divide occupy the back unit until done, multiply in two stages (partial
// products), divide one quotient bit a cycle through the shift-subtract unit.
// Reset: arst_n clears all valid flags, pointers and the back state at once.
// ----------------------------------------------------------------------------
module rv32im_execute_unit_top #(
	parameter int QueueDepth = rvx_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rvx_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output rvx_pkg::out_item_t out_data
);
	// front to queue
	logic f_valid, f_ready;
	rvx_pkg::work_t f_data;
	// queue to back
	logic q_valid, q_ready;
	rvx_pkg::work_t q_data;

	// classify each item and compute everything but mul/div
	rvx_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.w_valid(f_valid), .w_ready(f_ready), .w_data(f_data)
	);

	// hold items while the back unit is busy with a long operation
	rvx_queue #(.Depth(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.i_valid(f_valid), .i_ready(f_ready), .i_data(f_data),
		.o_valid(q_valid), .o_ready(q_ready), .o_data(q_data)
	);

	// finish mul/div and present the result item
	rvx_back u_back (
		.clk(clk), .arst_n(arst_n),
		.w_valid(q_valid), .w_ready(q_ready), .w_data(q_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);
endmodule

// ----- bench/tb_rv32im_execute_unit_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rv32im_execute_unit_top : self-checking bench for the RV32IM execute unit
// Drives directed and random instructions through the valid/ready input,
// predicts each result in the bench and compares it field by field with the
// items leaving the output channel, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_rv32im_execute_unit_top;

	localparam int ItemLimit = 390;
	localparam int CycleLimit = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	rvx_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rvx_pkg::out_item_t out_data;

	rvx_pkg::in_item_t pending_items[$];
	rvx_pkg::out_item_t expected_results[$];
	int mismatch_count = 0;
	int cycle_count = 0;
	int sender_gap = 0;
	int receiver_gap = 0;
	int receiver_hold = 0;    // long hold-off on the receive side
	bit pause_request = 1'b0; // sender waits until nothing is expected
	bit in_accepted = 1'b0;   // item on the input was taken at the last edge

	rv32im_execute_unit_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// sign-extend the low 'bits' bits of v
	function automatic logic [31:0] sign_extend(logic [31:0] v, int bits);
		logic [31:0] mask;
		mask = (bits == 32) ? '1 : ((32'd1 << bits) - 32'd1);
		v = v & mask;
		return v[bits-1] ? (v | ~mask) : v;
	endfunction

	// compute the result of one instruction
	function automatic rvx_pkg::out_item_t execute_instruction(rvx_pkg::in_item_t it);
		rvx_pkg::out_item_t r;
		logic [31:0] a, b, imm_i, addr, q;
		logic signed [63:0] prod_s;
		logic [63:0] prod_u;
		logic take;
		a = it.src_a;
		b = it.src_b;
		imm_i = sign_extend(it.imm_raw, 12);
		r = '0;
		r.next_pc = it.pc + 32'd4;
		take = 1'b0;
		case (it.mode)
			rvx_pkg::OP_LUI: begin r.rd_write = 1'b1; r.rd_value = it.imm_raw; end
			rvx_pkg::OP_AUIPC: begin r.rd_write = 1'b1; r.rd_value = it.pc + it.imm_raw; end
			rvx_pkg::OP_JAL: begin
				r.rd_write = 1'b1; r.rd_value = it.pc + 32'd4;
				r.next_pc = it.pc + sign_extend(it.imm_raw, 21);
			end
			rvx_pkg::OP_JALR: begin
				r.rd_write = 1'b1; r.rd_value = it.pc + 32'd4;
				r.next_pc = (a + imm_i) & 32'hFFFF_FFFE;
			end
			rvx_pkg::OP_BEQ, rvx_pkg::OP_BNE, rvx_pkg::OP_BLT, rvx_pkg::OP_BGE,
			rvx_pkg::OP_BLTU, rvx_pkg::OP_BGEU: begin
				case (it.mode)
					rvx_pkg::OP_BEQ: take = (a == b);
					rvx_pkg::OP_BNE: take = (a != b);
					rvx_pkg::OP_BLT: take = ($signed(a) < $signed(b));
					rvx_pkg::OP_BGE: take = !($signed(a) < $signed(b));
					rvx_pkg::OP_BLTU: take = (a < b);
					default: take = (a >= b);
				endcase
				if (take)
					r.next_pc = it.pc + sign_extend(it.imm_raw, 13);
			end
			rvx_pkg::OP_LB, rvx_pkg::OP_LH, rvx_pkg::OP_LW, rvx_pkg::OP_LBU,
			rvx_pkg::OP_LHU: begin
				addr = a + imm_i;
				r.mem_addr = addr;
				r.rd_write = 1'b1;
				case (it.mode)
					rvx_pkg::OP_LB:
						r.rd_value = sign_extend(it.load_word >> (addr[1:0] * 8), 8);
					rvx_pkg::OP_LH:
						r.rd_value = sign_extend(it.load_word >> (addr[1] * 16), 16);
					rvx_pkg::OP_LW: r.rd_value = it.load_word;
					rvx_pkg::OP_LBU:
						r.rd_value = (it.load_word >> (addr[1:0] * 8)) & 32'hFF;
					default: r.rd_value = (it.load_word >> (addr[1] * 16)) & 32'hFFFF;
				endcase
			end
			rvx_pkg::OP_SB, rvx_pkg::OP_SH, rvx_pkg::OP_SW: begin
				addr = a + imm_i;
				r.mem_addr = addr;
				case (it.mode)
					rvx_pkg::OP_SB: begin
						r.store_data = (b & 32'hFF) << (addr[1:0] * 8);
						r.byte_enable = 4'b0001 << addr[1:0];
					end
					rvx_pkg::OP_SH: begin
						r.store_data = (b & 32'hFFFF) << (addr[1] * 16);
						r.byte_enable = addr[1] ? 4'b1100 : 4'b0011;
					end
					default: begin r.store_data = b; r.byte_enable = 4'hF; end
				endcase
			end
			rvx_pkg::OP_ADDI: begin r.rd_write = 1'b1; r.rd_value = a + imm_i; end
			rvx_pkg::OP_SLTI: begin
				r.rd_write = 1'b1; r.rd_value = {31'd0, $signed(a) < $signed(imm_i)};
			end
			rvx_pkg::OP_SLTIU: begin r.rd_write = 1'b1; r.rd_value = {31'd0, a < imm_i}; end
			rvx_pkg::OP_XORI: begin r.rd_write = 1'b1; r.rd_value = a ^ imm_i; end
			rvx_pkg::OP_ORI: begin r.rd_write = 1'b1; r.rd_value = a | imm_i; end
			rvx_pkg::OP_ANDI: begin r.rd_write = 1'b1; r.rd_value = a & imm_i; end
			rvx_pkg::OP_SLLI: begin r.rd_write = 1'b1; r.rd_value = a << it.imm_raw[4:0]; end
			rvx_pkg::OP_SRLI: begin r.rd_write = 1'b1; r.rd_value = a >> it.imm_raw[4:0]; end
			rvx_pkg::OP_SRAI: begin
				r.rd_write = 1'b1; r.rd_value = $signed(a) >>> it.imm_raw[4:0];
			end
			rvx_pkg::OP_ADD: begin r.rd_write = 1'b1; r.rd_value = a + b; end
			rvx_pkg::OP_SUB: begin r.rd_write = 1'b1; r.rd_value = a - b; end
			rvx_pkg::OP_SLL: begin r.rd_write = 1'b1; r.rd_value = a << b[4:0]; end
			rvx_pkg::OP_SLT: begin
				r.rd_write = 1'b1; r.rd_value = {31'd0, $signed(a) < $signed(b)};
			end
			rvx_pkg::OP_SLTU: begin r.rd_write = 1'b1; r.rd_value = {31'd0, a < b}; end
			rvx_pkg::OP_XOR: begin r.rd_write = 1'b1; r.rd_value = a ^ b; end
			rvx_pkg::OP_SRL: begin r.rd_write = 1'b1; r.rd_value = a >> b[4:0]; end
			rvx_pkg::OP_SRA: begin r.rd_write = 1'b1; r.rd_value = $signed(a) >>> b[4:0]; end
			rvx_pkg::OP_OR: begin r.rd_write = 1'b1; r.rd_value = a | b; end
			rvx_pkg::OP_AND: begin r.rd_write = 1'b1; r.rd_value = a & b; end
			rvx_pkg::OP_MUL: begin r.rd_write = 1'b1; r.rd_value = a * b; end
			rvx_pkg::OP_MULH: begin
				prod_s = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
				r.rd_write = 1'b1; r.rd_value = prod_s[63:32];
			end
			rvx_pkg::OP_MULHSU: begin
				prod_s = $signed({{32{a[31]}}, a}) * $signed({32'd0, b});
				r.rd_write = 1'b1; r.rd_value = prod_s[63:32];
			end
			rvx_pkg::OP_MULHU: begin
				prod_u = {32'd0, a} * {32'd0, b};
				r.rd_write = 1'b1; r.rd_value = prod_u[63:32];
			end
			rvx_pkg::OP_DIV: begin
				r.rd_write = 1'b1;
				if (b == '0) r.rd_value = '1;
				else if (a == 32'h8000_0000 && b == '1) r.rd_value = a;
				else begin
					q = (a[31] ? -a : a) / (b[31] ? -b : b);
					r.rd_value = (a[31] ^ b[31]) ? -q : q;
				end
			end
			rvx_pkg::OP_DIVU: begin
				r.rd_write = 1'b1; r.rd_value = (b == '0) ? '1 : a / b;
			end
			rvx_pkg::OP_REM: begin
				r.rd_write = 1'b1;
				if (b == '0) r.rd_value = a;
				else if (a == 32'h8000_0000 && b == '1) r.rd_value = '0;
				else begin
					q = (a[31] ? -a : a) % (b[31] ? -b : b);
					r.rd_value = a[31] ? -q : q;
				end
			end
			rvx_pkg::OP_REMU: begin
				r.rd_write = 1'b1; r.rd_value = (b == '0) ? a : a % b;
			end
			rvx_pkg::OP_ECALL: r.syscall = 1'b1;
			default: ; // nop and undefined codes
		endcase
		return r;
	endfunction

	function automatic logic [31:0] random_word();
		case ($urandom_range(0, 5))
			0: return 32'd0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return $urandom_range(0, 15);
			default: return $urandom;
		endcase
	endfunction

	function automatic rvx_pkg::in_item_t make_item(logic [5:0] op, logic [31:0] a,
			logic [31:0] b, logic [31:0] imm);
		rvx_pkg::in_item_t it;
		it.mode = op;
		it.src_a = a;
		it.src_b = b;
		it.imm_raw = imm;
		it.pc = $urandom;
		it.load_word = $urandom;
		return it;
	endfunction

	// driver: hold each item until accepted, then draw a fresh gap
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_accepted) begin
				// hold
			end else if (pause_request && expected_results.size() != 0) begin
				in_valid <= 1'b0;
			end else if (sender_gap > 0) begin
				sender_gap <= sender_gap - 1;
				in_valid <= 1'b0;
			end else if (pending_items.size() != 0) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
				sender_gap <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 10)) : 0;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// record the expectation when the block takes an item
	always @(posedge clk) begin
		in_accepted <= in_valid && in_ready;
		if (in_valid && in_ready)
			expected_results.push_back(execute_instruction(in_data));
	end

	// receiver: random idling, plus a long hold-off counted here
	always @(negedge clk) begin
		if (arst_n) begin
			if (receiver_hold > 0) begin
				receiver_hold <= receiver_hold - 1;
				out_ready <= 1'b0;
			end else if (cycle_count == 300) begin
				receiver_hold <= 200;
				out_ready <= 1'b0;
			end else if (receiver_gap > 0) begin
				receiver_gap <= receiver_gap - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				receiver_gap <= ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 10)) : 0;
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		rvx_pkg::out_item_t want;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				mismatch_count <= mismatch_count + 1;
				if (mismatch_count < 10)
					$display("unexpected item %h", out_data);
			end else begin
				want = expected_results.pop_front();
				if (want !== out_data) begin
					mismatch_count <= mismatch_count + 1;
					if (mismatch_count < 10)
						$display({"mismatch: wr %b/%b rd %h/%h npc %h/%h addr %h/%h",
							" sd %h/%h be %h/%h sys %b/%b"},
							want.rd_write, out_data.rd_write, want.rd_value, out_data.rd_value,
							want.next_pc, out_data.next_pc, want.mem_addr, out_data.mem_addr,
							want.store_data, out_data.store_data, want.byte_enable,
							out_data.byte_enable, want.syscall, out_data.syscall);
				end
			end
		end
	end

	// time limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("tb_rv32im_execute_unit_top failed");
			$finish;
		end
	end

	initial begin
		int settle;
		logic [5:0] op;
		// directed: extremes, every operation, division corner cases, lanes
		for (int k = 0; k <= 46; k++)
			pending_items.push_back(make_item(k[5:0], random_word(), random_word(), $urandom));
		pending_items.push_back(make_item(rvx_pkg::OP_DIV, 32'h8000_0000, '1, '0));
		pending_items.push_back(make_item(rvx_pkg::OP_REM, 32'h8000_0000, '1, '0));
		pending_items.push_back(make_item(rvx_pkg::OP_DIV, $urandom, '0, '0));
		pending_items.push_back(make_item(rvx_pkg::OP_REMU, $urandom, '0, '0));
		pending_items.push_back(make_item(rvx_pkg::OP_SRAI, 32'h8000_0000, '0, 32'hFFFF_FFFF));
		pending_items.push_back(make_item(rvx_pkg::OP_JALR, '1, '0, 32'hFFF));
		pending_items.push_back(make_item(6'd63, '1, '1, '1));
		for (int k = 0; k < 4; k++) begin
			pending_items.push_back(make_item(rvx_pkg::OP_SB, k, $urandom, 32'hFFFF_F000));
			pending_items.push_back(make_item(rvx_pkg::OP_LB, k, '0, '0));
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// random: mostly defined codes, some undefined ones
		for (int n = 0; n < ItemLimit; n++) begin
			op = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(47, 63))
				: 6'($urandom_range(0, 46));
			pending_items.push_back(make_item(op, random_word(), random_word(), random_word()));
		end

		// pause the sender once until the block has drained
		wait (pending_items.size() < ItemLimit / 2);
		pause_request = 1'b1;
		wait (expected_results.size() == 0);
		@(negedge clk);
		pause_request = 1'b0;

		wait (pending_items.size() == 0);
		@(negedge clk);
		wait (!in_valid);
		wait (expected_results.size() == 0);
		settle = 0;
		while (settle < 50) begin
			@(posedge clk);
			settle++;
		end
		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("tb_rv32im_execute_unit_top passed");
		else
			$display("tb_rv32im_execute_unit_top failed");
		$finish;
	end

endmodule

// ----- rv32im_execute_unit_top.f -----
design/rvx_pkg.sv
design/rvx_front.sv
design/rvx_queue.sv
design/rvx_back.sv
design/rv32im_execute_unit_top.sv
bench/tb_rv32im_execute_unit_top.sv
